FILE: sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// shared widths, codes and types of the fit policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

   // fixed field widths of the channels
   localparam int REQ_TYPE_BITS    = 1;
   localparam int BLOCK_INDEX_BITS = 4;
   localparam int SIZE_VALUE_BITS  = 16;
   localparam int POLICY_BITS      = 2;
   localparam int COUNT_BITS       = 5;
   localparam int CSR_INDEX_BITS   = 4;
   localparam int CSR_DATA_BITS    = 8;

   // parameter defaults
   localparam int DEF_NUM_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_COUNT = 4'd1;

   // request kinds
   localparam logic [REQ_TYPE_BITS-1:0] REQ_LOAD  = 1'b0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_ALLOC = 1'b1;

   // placement rules, the unused code behaves as first fit
   typedef enum logic [POLICY_BITS-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_policy_type;

   // control part of the search record moving along the cell row
   typedef struct packed {
      logic           active;
      logic           found;
      fit_policy_type policy;
   } cand_ctl_type;

endpackage

FILE: sv/fpba_ifs.sv
// ----------------------------------------------------------------------------
// fpba channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface fpba_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [fpba_pkg::REQ_TYPE_BITS-1:0]     req_type;
   logic [fpba_pkg::BLOCK_INDEX_BITS-1:0]  block_index;
   logic [fpba_pkg::SIZE_VALUE_BITS-1:0]   size_value;

   modport source (output valid, output req_type, output block_index,
                   output size_value, input ready);
   modport sink   (input valid, input req_type, input block_index,
                   input size_value, output ready);
endinterface

interface fpba_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   granted;
   logic [fpba_pkg::BLOCK_INDEX_BITS-1:0]  chosen_block;
   logic [fpba_pkg::SIZE_VALUE_BITS-1:0]   space_left;

   modport source (output valid, output granted, output chosen_block,
                   output space_left, input ready);
   modport sink   (input valid, input granted, input chosen_block,
                   input space_left, output ready);
endinterface

interface fpba_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [fpba_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [fpba_pkg::CSR_DATA_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/fpba_cell.sv
// ----------------------------------------------------------------------------
// fpba_cell
// one block's free capacity plus one stage of the placement search
// ----------------------------------------------------------------------------
module fpba_cell #(
   parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS,
   parameter int INDEX      = 0,
   localparam int IDX_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [fpba_pkg::COUNT_BITS-1:0]  block_count,
   input  logic                             wr_en,
   input  logic [IDX_BITS-1:0]              wr_idx,
   input  logic [SIZE_BITS-1:0]             wr_data,
   input  fpba_pkg::cand_ctl_type           ctl_in,
   input  logic [IDX_BITS-1:0]              pick_in,
   input  logic [SIZE_BITS-1:0]             best_in,
   input  logic [SIZE_BITS-1:0]             size_in,
   output fpba_pkg::cand_ctl_type           ctl_out,
   output logic [IDX_BITS-1:0]              pick_out,
   output logic [SIZE_BITS-1:0]             best_out,
   output logic [SIZE_BITS-1:0]             size_out
);
   import fpba_pkg::*;

   logic [SIZE_BITS-1:0] cap_ff;
   cand_ctl_type         ctl_ff;
   cand_ctl_type         ctl_in_nx;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [SIZE_BITS-1:0] best_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic                 in_use;
   logic                 hit;
   logic                 take;

   assign in_use = int'(block_count) > INDEX;
   assign hit    = ctl_in.active && in_use && (cap_ff >= size_in);

   // replace the current pick only when the rule prefers this block
   always_comb begin
      take = 1'b0;
      if (hit) begin
         if (!ctl_in.found) begin
            take = 1'b1;
         end else if (ctl_in.policy == FIT_BEST) begin
            take = cap_ff < best_in;
         end else if (ctl_in.policy == FIT_WORST) begin
            take = cap_ff > best_in;
         end
      end
   end

   always_comb begin
      ctl_in_nx       = ctl_in;
      ctl_in_nx.found = ctl_in.found | hit;
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IDX_BITS'(INDEX))) begin
         cap_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= take ? IDX_BITS'(INDEX) : pick_in;
      best_ff <= take ? cap_ff : best_in;
      size_ff <= size_in;
   end

   assign ctl_out  = ctl_ff;
   assign pick_out = pick_ff;
   assign best_out = best_ff;
   assign size_out = size_ff;

endmodule

FILE: sv/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// first / best / worst fit placement over a row of capacity cells
// ----------------------------------------------------------------------------
// a load writes its cell at its accept edge and gives no response
// an allocation passes the start register, every cell, the outcome register and
//    then the response register; done waits while rsp stalls, and no new request
//    is taken until the result has moved into the response register
// reset: synchronous, clears policy (first fit), block count and control
//    state; capacities are undefined until loaded, no request taken in reset
module fit_policy_block_allocator #(
   parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   fpba_req_if.sink    req_ch,
   fpba_rsp_if.source  rsp_ch,
   fpba_csr_if.sink    csr_ch
);
   import fpba_pkg::*;

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   // one-hot control
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   fit_policy_type       fit_policy_ff;
   logic [COUNT_BITS-1:0] block_count_ff;

   // head of the cell row, holds the fresh search record for one cycle
   cand_ctl_type         start_ctl_ff, start_ctl_in;
   logic [SIZE_BITS-1:0] start_size_ff;

   // chain links, element k feeds cell k, the last one is the result
   cand_ctl_type         ctl_chain  [NUM_BLOCKS+1];
   logic [IDX_BITS-1:0]  pick_chain [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0] best_chain [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0] size_chain [NUM_BLOCKS+1];

   // shared write port of the cells
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [SIZE_BITS-1:0] wr_data;

   // search outcome waiting for the response register
   logic                 pend_granted_ff;
   logic [IDX_BITS-1:0]  pend_pick_ff;
   logic [SIZE_BITS-1:0] pend_left_ff;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_granted_ff;
   logic [BLOCK_INDEX_BITS-1:0] rsp_block_ff;
   logic [SIZE_VALUE_BITS-1:0]  rsp_left_ff;

   logic                 req_fire;
   logic                 load_fire;
   logic                 alloc_fire;
   logic                 load_in_range;
   logic                 scan_end;
   logic [SIZE_BITS-1:0] fin_left;
   logic                 rsp_free;

   cand_ctl_type         fin_ctl;
   logic [IDX_BITS-1:0]  fin_pick;
   logic [SIZE_BITS-1:0] fin_best;
   logic [SIZE_BITS-1:0] fin_size;

   // handshakes, nothing is taken while in reset
   assign req_ch.ready  = !reset && (state_ff == ST_IDLE);
   assign csr_ch.ready  = !reset && (state_ff == ST_IDLE);
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign load_fire     = req_fire && (req_ch.req_type == REQ_LOAD);
   assign alloc_fire    = req_fire && (req_ch.req_type == REQ_ALLOC);
   assign load_in_range = int'(req_ch.block_index) < NUM_BLOCKS;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;

   // tail of the cell row
   assign fin_ctl  = ctl_chain[NUM_BLOCKS];
   assign fin_pick = pick_chain[NUM_BLOCKS];
   assign fin_best = best_chain[NUM_BLOCKS];
   assign fin_size = size_chain[NUM_BLOCKS];
   assign scan_end = (state_ff == ST_SCAN) && fin_ctl.active;
   assign fin_left = fin_best - fin_size;

   // register writes, only taken while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff  <= FIT_FIRST;
         block_count_ff <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_FIT_POLICY:  fit_policy_ff  <= fit_policy_type'(csr_ch.data[POLICY_BITS-1:0]);
            CSR_BLOCK_COUNT: block_count_ff <= csr_ch.data[COUNT_BITS-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // cell write port: a load from the request, or the write-back after a search
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = IDX_BITS'(req_ch.block_index);
      wr_data = SIZE_BITS'(req_ch.size_value);
      if (load_fire && load_in_range) begin
         wr_en = 1'b1;
      end else if (scan_end && fin_ctl.found) begin
         wr_en   = 1'b1;
         wr_idx  = fin_pick;
         wr_data = fin_left;
      end
   end

   // launch of a search record at the head of the row
   always_comb begin
      start_ctl_in        = '0;
      start_ctl_in.active = alloc_fire;
      start_ctl_in.found  = 1'b0;
      start_ctl_in.policy = fit_policy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ctl_ff <= '0;
      end else begin
         start_ctl_ff <= start_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc_fire) begin
         start_size_ff <= SIZE_BITS'(req_ch.size_value);
      end
   end

   assign ctl_chain[0]  = start_ctl_ff;
   assign pick_chain[0] = '0;
   assign best_chain[0] = '0;
   assign size_chain[0] = start_size_ff;

   // the row of cells, the search record moves one cell per cycle
   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      fpba_cell #(
         .NUM_BLOCKS (NUM_BLOCKS),
         .SIZE_BITS  (SIZE_BITS),
         .INDEX      (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .block_count (block_count_ff),
         .wr_en       (wr_en),
         .wr_idx      (wr_idx),
         .wr_data     (wr_data),
         .ctl_in      (ctl_chain[k]),
         .pick_in     (pick_chain[k]),
         .best_in     (best_chain[k]),
         .size_in     (size_chain[k]),
         .ctl_out     (ctl_chain[k+1]),
         .pick_out    (pick_chain[k+1]),
         .best_out    (best_chain[k+1]),
         .size_out    (size_chain[k+1])
      );
   end

   // control sequence: idle -> scan -> done (wait for a free response slot)
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (alloc_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fin_ctl.active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the search outcome
   always_ff @(posedge clock) begin
      if (scan_end) begin
         pend_granted_ff <= fin_ctl.found;
         pend_pick_ff    <= fin_pick;
         pend_left_ff    <= fin_left;
      end
   end

   // response register, zero fields when nothing fits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_granted_ff <= pend_granted_ff;
         rsp_block_ff   <= pend_granted_ff ? BLOCK_INDEX_BITS'(pend_pick_ff) : '0;
         rsp_left_ff    <= pend_granted_ff ? SIZE_VALUE_BITS'(pend_left_ff) : '0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted      = rsp_granted_ff;
   assign rsp_ch.chosen_block = rsp_block_ff;
   assign rsp_ch.space_left   = rsp_left_ff;

endmodule
